@@ design/prw_pkg.sv @@
// Package for the per-session replay window: sizes, codes, entry and update types.
// No dependencies; imported by per_session_replay_window and prw_update.
`default_nettype none

package prw_pkg;

    localparam int SLOTS    = 16;
    localparam int WINDOW   = 64;
    localparam int SEQ_W    = 32;
    localparam int SLOT_IN_W = 4;
    localparam int SLOT_IN_N = 1 << SLOT_IN_W;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DIST_W   = $clog2(WINDOW);
    localparam int ENTRY_W  = SEQ_W + WINDOW;

    typedef enum logic {
        OP_CHECK = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        VD_FIRST     = 3'd0,
        VD_NEWER     = 3'd1,
        VD_IN_WINDOW = 3'd2,
        VD_ZERO      = 3'd3,
        VD_TOO_OLD   = 3'd4,
        VD_DUPLICATE = 3'd5,
        VD_CLEARED   = 3'd6
    } t_verdict;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0]  hw;
        logic [WINDOW-1:0] bm;
    } t_entry;

    typedef struct packed {
        logic     wr_en;
        t_entry   entry;
        logic     accept;
        t_verdict verdict;
    } t_upd;

    typedef logic [SLOT_W-1:0] t_slot_map [SLOT_IN_N];

    // Slot field wraps onto the slot count; built at elaboration.
    function automatic t_slot_map build_slot_map();
        t_slot_map m;
        for (int i = 0; i < SLOT_IN_N; i++) begin
            m[i] = SLOT_W'(i % SLOTS);
        end
        return m;
    endfunction

    localparam t_slot_map SLOT_MAP = build_slot_map();

endpackage

`default_nettype wire

@@ design/per_session_replay_window.sv @@
// Top level of the per-session anti-replay window: slot store, sequencer, output register.
// Depends on prw_pkg, prw_ram and prw_update.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+--------------------------------
//   check   | in        | i_valid / o_stall | i_operation, i_slot, i_frame_seq
//   verdict | out       | o_valid / i_stall | o_accept, o_verdict
//
// For each beat, the accept edge reads the slot entry from the RAM into its read
// register; in ST_CALC the entry is written back and the output register is loaded.
// Valid bits per slot are cleared by reset at once; an unwritten slot reads as zero.
// A clear beat only drops the slot's valid bit.
// The input stalls in ST_CALC, and in ST_IDLE only when a waiting result meets a stalled output.
`default_nettype none

module per_session_replay_window
    import prw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_operation,
    input  wire logic [SLOT_IN_W-1:0] i_slot,
    input  wire logic [SEQ_W-1:0]     i_frame_seq,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_accept,
    output logic [2:0]                o_verdict
);

    t_state            r_state;
    t_state            n_state;
    logic              r_op;
    logic [SLOT_W-1:0] r_slot;
    logic [SEQ_W-1:0]  r_seq;
    logic [SLOTS-1:0]  r_vld;
    logic              r_out_valid;
    logic              r_accept;
    t_verdict          r_verdict;

    logic              in_take;
    logic              calc;
    logic [SLOT_W-1:0] in_slot;
    logic [ENTRY_W-1:0] rd_data;
    t_entry            cur_entry;
    t_upd              upd;

    assign in_slot = SLOT_MAP[i_slot];
    assign in_take = i_valid && !o_stall;

    prw_ram #(
        .P_WIDTH (ENTRY_W),
        .P_DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (calc && upd.wr_en),
        .i_waddr (r_slot),
        .i_wdata (upd.entry),
        .i_raddr (in_slot),
        .o_rdata (rd_data)
    );

    assign cur_entry = r_vld[r_slot] ? t_entry'(rd_data) : '0;

    prw_update u_update (
        .i_op    (r_op),
        .i_seq   (r_seq),
        .i_entry (cur_entry),
        .o_upd   (upd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        calc    = 1'b0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = r_out_valid && i_stall;
            end
            ST_CALC: begin
                calc = 1'b1;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (calc) begin
                if (r_op == OP_CLEAR) begin
                    r_vld[r_slot] <= 1'b0;
                end else if (upd.wr_en) begin
                    r_vld[r_slot] <= 1'b1;
                end
            end
            priority if (calc) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the beat while its entry is read, and register its result in ST_CALC
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= i_operation;
            r_slot <= in_slot;
            r_seq  <= i_frame_seq;
        end
        if (calc) begin
            r_accept  <= upd.accept;
            r_verdict <= upd.verdict;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_accept  = r_accept;
    assign o_verdict = r_verdict;

endmodule

`default_nettype wire

@@ design/prw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module prw_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16,
    parameter int P_ADDR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [P_ADDR_W-1:0] i_waddr,
    input  wire logic [P_WIDTH-1:0]  i_wdata,
    input  wire logic [P_ADDR_W-1:0] i_raddr,
    output logic      [P_WIDTH-1:0]  o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/prw_update.sv @@
// Window update: classifies one frame sequence against a slot entry and builds
// the write-back entry. Depends on prw_pkg.
`default_nettype none

module prw_update
    import prw_pkg::*;
(
    input  wire logic             i_op,
    input  wire logic [SEQ_W-1:0] i_seq,
    input  wire t_entry           i_entry,
    output t_upd                  o_upd
);

    logic [SEQ_W-1:0] delta_up;
    logic [SEQ_W-1:0] delta_dn;

    assign delta_up = i_seq - i_entry.hw;
    assign delta_dn = i_entry.hw - i_seq;

    always_comb begin
        o_upd.wr_en   = 1'b0;
        o_upd.entry   = i_entry;
        o_upd.accept  = 1'b0;
        o_upd.verdict = VD_ZERO;
        priority if (i_op == OP_CLEAR) begin
            o_upd.verdict = VD_CLEARED;
        end else if (i_seq == '0) begin
            o_upd.verdict = VD_ZERO;
        end else if (i_entry.hw == '0) begin
            o_upd.wr_en    = 1'b1;
            o_upd.entry.hw = i_seq;
            o_upd.entry.bm = WINDOW'(1);
            o_upd.accept   = 1'b1;
            o_upd.verdict  = VD_FIRST;
        end else if (i_seq > i_entry.hw) begin
            o_upd.wr_en    = 1'b1;
            o_upd.entry.hw = i_seq;
            // a jump past the window leaves only the new frame
            if (delta_up >= SEQ_W'(WINDOW)) begin
                o_upd.entry.bm = WINDOW'(1);
            end else begin
                o_upd.entry.bm = (i_entry.bm << delta_up[DIST_W-1:0]) | WINDOW'(1);
            end
            o_upd.accept   = 1'b1;
            o_upd.verdict  = VD_NEWER;
        end else if (delta_dn >= SEQ_W'(WINDOW)) begin
            o_upd.verdict = VD_TOO_OLD;
        end else if (i_entry.bm[delta_dn[DIST_W-1:0]]) begin
            o_upd.verdict = VD_DUPLICATE;
        end else begin
            o_upd.wr_en    = 1'b1;
            o_upd.entry.bm = i_entry.bm | (WINDOW'(1) << delta_dn[DIST_W-1:0]);
            o_upd.accept   = 1'b1;
            o_upd.verdict  = VD_IN_WINDOW;
        end
    end

endmodule

`default_nettype wire
